// ----- design/lcr_pkg.sv -----
// Shared types, widths and codes for the line rasterizer with color interpolation.
// No dependencies; imported by lcr_div and parametric_line_color_rasterizer_unit.
`timescale 1ns / 1ps

package lcr_pkg;

   // Coordinate and color widths
   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 8;

   // Quotient of one interpolation: covers both coordinate and color spans
   localparam int QUO_BITS  = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;
   localparam int DIFF_BITS = QUO_BITS + 1;
   // Dividend 2*k*|d| + n - neg, divisor 2*n
   localparam int NUM_BITS  = COORD_BITS + QUO_BITS + 1;
   localparam int REM_BITS  = COORD_BITS + 1;
   localparam int CNT_BITS  = $clog2(QUO_BITS + 1);

   // Register file
   localparam int CSR_BITS = 3;
   localparam logic [CSR_BITS-1:0] CSR_START_RED   = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_START_GREEN = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_START_BLUE  = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_END_RED     = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_END_GREEN   = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_END_BLUE    = 3'd5;

   localparam logic [COLOR_BITS-1:0] COLOR_FULL = '1;

   // Request opcode
   localparam logic OP_START = 1'b0;

   typedef logic signed [DIFF_BITS-1:0] diff_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CH_X,
      CH_Y,
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] dividend;
      logic [REM_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- design/lcr_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all five channels.
// Depends on lcr_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module lcr_div import lcr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  div_req_type         div_req,
   output div_stat_type        div_stat,
   output logic [QUO_BITS-1:0] quotient
);

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [REM_BITS:0]   trial;
   logic [REM_BITS:0]   sub;
   logic                fits;

   // Trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, quo_ff[QUO_BITS-1]};
      sub   = trial - {1'b0, div_req.divisor};
      fits  = trial >= {1'b0, div_req.divisor};
   end

   // Load on start, otherwise iterate until the count runs out
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         // Upper bits are known to be below the divisor
         rem_in = div_req.dividend[NUM_BITS-1:QUO_BITS];
         quo_in = div_req.dividend[QUO_BITS-1:0];
         cnt_in = CNT_BITS'(QUO_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? sub[REM_BITS-1:0] : trial[REM_BITS-1:0];
         quo_in  = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_stat.busy = (cnt_ff != '0);
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;

endmodule

// ----- design/parametric_line_color_rasterizer_unit.sv -----
// Line rasterizer with color interpolation. Start item: the first point passes through the setup
// and emit states. Next item: five interpolations through one multiplier and one bit-serial
// divider, each channel a multiply state then a divide state, then the point goes to the emit state.
// One item in flight; the request side reopens the cycle after the result is loaded, and the
// emit state holds the result while the response side stalls.
// Synchronous active-high reset: no line, start colors 0, end colors 255, no result pending.
`timescale 1ns / 1ps

module parametric_line_color_rasterizer_unit import lcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_valid_res,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_red,
   output logic [COLOR_BITS-1:0] rsp_green,
   output logic [COLOR_BITS-1:0] rsp_blue,
   output logic                  rsp_last,
   // Register write port
   input  logic                  csr_write,
   input  logic [CSR_BITS-1:0]   csr_index,
   input  logic [COLOR_BITS-1:0] csr_data
);

   // Color registers
   logic [COLOR_BITS-1:0] start_red_ff, start_green_ff, start_blue_ff;
   logic [COLOR_BITS-1:0] end_red_ff, end_green_ff, end_blue_ff;

   // Line state
   state_type             state_ff, state_in;
   chan_type              ch_ff, ch_in;
   logic [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic signed [COORD_BITS:0] delta_x_ff, delta_x_in;
   logic signed [COORD_BITS:0] delta_y_ff, delta_y_in;
   logic [COORD_BITS-1:0] total_ff, total_in;
   logic [COORD_BITS-1:0] step_ff, step_in;
   logic                  active_ff, active_in;
   logic                  final_ff, final_in;

   // Point being assembled
   logic                  pt_valid_ff, pt_valid_in;
   logic [COORD_BITS-1:0] pt_x_ff, pt_x_in;
   logic [COORD_BITS-1:0] pt_y_ff, pt_y_in;
   logic [COLOR_BITS-1:0] pt_r_ff, pt_r_in;
   logic [COLOR_BITS-1:0] pt_g_ff, pt_g_in;
   logic [COLOR_BITS-1:0] pt_b_ff, pt_b_in;
   logic                  pt_last_ff, pt_last_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_vres_ff;
   logic [COORD_BITS-1:0] rsp_x_ff;
   logic [COORD_BITS-1:0] rsp_y_ff;
   logic [COLOR_BITS-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic                  rsp_last_ff;
   logic                  rsp_load;

   // Shared datapath
   logic                  req_xfer;
   logic [COORD_BITS-1:0] mag_x, mag_y;
   logic [COORD_BITS-1:0] step_next;
   logic [QUO_BITS-1:0]   base_sel;
   diff_type              diff_sel;
   logic                  neg_sel;
   logic [QUO_BITS-1:0]   mag_sel;
   logic [COORD_BITS+QUO_BITS-1:0] prod;
   logic [NUM_BITS-1:0]   num;
   logic [QUO_BITS:0]     res_sel;
   div_req_type           div_req;
   div_stat_type          div_stat;
   logic [QUO_BITS-1:0]   quotient;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign step_next = step_ff + 1'b1;

   // Absolute deltas for the step count
   assign mag_x = delta_x_ff[COORD_BITS] ? COORD_BITS'(-delta_x_ff) : COORD_BITS'(delta_x_ff);
   assign mag_y = delta_y_ff[COORD_BITS] ? COORD_BITS'(-delta_y_ff) : COORD_BITS'(delta_y_ff);

   // Select base and span of the current channel
   always_comb begin
      case (ch_ff)
         CH_X: begin
            base_sel = QUO_BITS'(origin_x_ff);
            diff_sel = diff_type'(delta_x_ff);
         end
         CH_Y: begin
            base_sel = QUO_BITS'(origin_y_ff);
            diff_sel = diff_type'(delta_y_ff);
         end
         CH_RED: begin
            base_sel = QUO_BITS'(start_red_ff);
            diff_sel = diff_type'($signed({1'b0, end_red_ff}) - $signed({1'b0, start_red_ff}));
         end
         CH_GREEN: begin
            base_sel = QUO_BITS'(start_green_ff);
            diff_sel = diff_type'($signed({1'b0, end_green_ff})
                                  - $signed({1'b0, start_green_ff}));
         end
         CH_BLUE: begin
            base_sel = QUO_BITS'(start_blue_ff);
            diff_sel = diff_type'($signed({1'b0, end_blue_ff}) - $signed({1'b0, start_blue_ff}));
         end
         default: begin
            base_sel = '0;
            diff_sel = '0;
         end
      endcase
   end

   // Round-half-up of k*d/n: base +/- floor((2k|d| + n - neg) / 2n)
   always_comb begin
      neg_sel = diff_sel[DIFF_BITS-1];
      mag_sel = neg_sel ? QUO_BITS'(-diff_sel) : QUO_BITS'(diff_sel);
      prod    = step_ff * mag_sel;
      num     = {prod, 1'b0} + NUM_BITS'(total_ff) - NUM_BITS'(neg_sel);
      res_sel = neg_sel ? ({1'b0, base_sel} - {1'b0, quotient})
                        : ({1'b0, base_sel} + {1'b0, quotient});
   end

   assign div_req.start    = (state_ff == ST_MUL);
   assign div_req.dividend = num;
   assign div_req.divisor  = {total_ff, 1'b0};

   lcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat),
      .quotient (quotient)
   );

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      delta_x_in  = delta_x_ff;
      delta_y_in  = delta_y_ff;
      total_in    = total_ff;
      step_in     = step_ff;
      active_in   = active_ff;
      final_in    = final_ff;
      pt_valid_in = pt_valid_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      pt_r_in     = pt_r_ff;
      pt_g_in     = pt_g_ff;
      pt_b_in     = pt_b_ff;
      pt_last_in  = pt_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_START) begin
                  origin_x_in = req_x_start;
                  origin_y_in = req_y_start;
                  delta_x_in  = $signed({1'b0, req_x_end}) - $signed({1'b0, req_x_start});
                  delta_y_in  = $signed({1'b0, req_y_end}) - $signed({1'b0, req_y_start});
                  state_in    = ST_SETUP;
               end else if (active_ff) begin
                  step_in   = step_next;
                  final_in  = (step_next >= total_ff);
                  active_in = (step_next < total_ff);
                  ch_in     = CH_X;
                  state_in  = ST_MUL;
               end else begin
                  // No line: empty result
                  pt_valid_in = 1'b0;
                  pt_x_in     = '0;
                  pt_y_in     = '0;
                  pt_r_in     = '0;
                  pt_g_in     = '0;
                  pt_b_in     = '0;
                  pt_last_in  = 1'b0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_SETUP: begin
            total_in    = (mag_x > mag_y) ? mag_x : mag_y;
            step_in     = '0;
            active_in   = (total_in != '0);
            pt_valid_in = 1'b1;
            pt_x_in     = origin_x_ff;
            pt_y_in     = origin_y_ff;
            pt_r_in     = start_red_ff;
            pt_g_in     = start_green_ff;
            pt_b_in     = start_blue_ff;
            pt_last_in  = (total_in == '0);
            state_in    = ST_EMIT;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_MUL;
               case (ch_ff)
                  CH_X: begin
                     pt_x_in = COORD_BITS'(res_sel);
                     ch_in   = CH_Y;
                  end
                  CH_Y: begin
                     pt_y_in = COORD_BITS'(res_sel);
                     ch_in   = CH_RED;
                  end
                  CH_RED: begin
                     pt_r_in = COLOR_BITS'(res_sel);
                     ch_in   = CH_GREEN;
                  end
                  CH_GREEN: begin
                     pt_g_in = COLOR_BITS'(res_sel);
                     ch_in   = CH_BLUE;
                  end
                  CH_BLUE: begin
                     pt_b_in     = COLOR_BITS'(res_sel);
                     pt_valid_in = 1'b1;
                     pt_last_in  = final_ff;
                     state_in    = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= CH_X;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         delta_x_ff   <= '0;
         delta_y_ff   <= '0;
         total_ff     <= '0;
         step_ff      <= '0;
         active_ff    <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         active_ff    <= active_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Point and output payload
   always_ff @(posedge clock) begin
      pt_valid_ff <= pt_valid_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      pt_r_ff     <= pt_r_in;
      pt_g_ff     <= pt_g_in;
      pt_b_ff     <= pt_b_in;
      pt_last_ff  <= pt_last_in;
      if (rsp_load) begin
         rsp_vres_ff <= pt_valid_ff;
         rsp_x_ff    <= pt_x_ff;
         rsp_y_ff    <= pt_y_ff;
         rsp_r_ff    <= pt_r_ff;
         rsp_g_ff    <= pt_g_ff;
         rsp_b_ff    <= pt_b_ff;
         rsp_last_ff <= pt_last_ff;
      end
   end

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_red_ff   <= '0;
         start_green_ff <= '0;
         start_blue_ff  <= '0;
         end_red_ff     <= COLOR_FULL;
         end_green_ff   <= COLOR_FULL;
         end_blue_ff    <= COLOR_FULL;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_RED:   start_red_ff   <= csr_data;
            CSR_START_GREEN: start_green_ff <= csr_data;
            CSR_START_BLUE:  start_blue_ff  <= csr_data;
            CSR_END_RED:     end_red_ff     <= csr_data;
            CSR_END_GREEN:   end_green_ff   <= csr_data;
            CSR_END_BLUE:    end_blue_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_vres_ff;
   assign rsp_pixel_x   = rsp_x_ff;
   assign rsp_pixel_y   = rsp_y_ff;
   assign rsp_red       = rsp_r_ff;
   assign rsp_green     = rsp_g_ff;
   assign rsp_blue      = rsp_b_ff;
   assign rsp_last      = rsp_last_ff;

   // An active line always has points left
   a_active_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (total_ff != '0) && (step_ff < total_ff))
      else $error("active line with no steps left");

   // The divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside divide state");

   // A new result only appears out of the emit state
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("response raised outside emit");

   // A next item on an active line always leads to a divider run
   a_next_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> div_stat.busy)
      else $error("divider not started");

endmodule
